// ===== design/cst_pkg.sv =====
// Shared constants, character codes and transaction types for the tokeniser.
// No dependencies; every design module refers to it by scoped names.
package cst_pkg;

  localparam int unsigned NEST_LIMIT = 255;
  localparam int unsigned NEST_W     = $clog2(NEST_LIMIT + 1);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // one result of the output stream, without its run_last mark
  typedef struct packed {
    logic [7:0] token_byte;
    logic       byte_valid;
    logic       token_end;
  } res_t;

  // work handed from the classifier to the emitter: one or two results
  typedef struct packed {
    logic two;
    res_t first;
    res_t second;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== design/cst_stream_if.sv =====
// Handshake channel interfaces for the tokeniser's input and result streams.
// Depends on nothing; carries valid, ready and the payload fields.
interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface cst_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_byte;
  logic       byte_valid;
  logic       token_end;
  logic       run_last;
  modport source (output valid, token_byte, byte_valid, token_end, run_last, input ready);
  modport sink   (input valid, token_byte, byte_valid, token_end, run_last, output ready);
endinterface

// ===== design/cst_front.sv =====
// Classifier: scanner FSM, one input transaction per cycle while the
// queue has room. Depends on cst_pkg; pushes 0 or 1 job of 1-2 results.
module cst_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_text_byte,
  input  logic              in_end_of_text,
  input  cst_pkg::q_status_t q_status,
  output logic              push,
  output cst_pkg::job_t     push_job
);

  typedef enum logic [1:0] {
    MODE_START,
    MODE_WORD,
    MODE_BLOCK,
    MODE_COMMENT
  } mode_t;

  mode_t                      mode_r, mode_nxt;
  logic                       quote_r, quote_nxt;
  logic [cst_pkg::NEST_W-1:0] nest_r, nest_nxt;
  logic                       slash_r, slash_nxt;
  logic                       drop_r, drop_nxt;

  logic          accept;
  logic          is_space, is_single;
  logic          run_start;
  logic          pre_vld, main_vld;
  cst_pkg::res_t pre_res, main_res;
  logic [7:0]    b;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign b        = in_text_byte;

  assign is_space = (b == cst_pkg::CH_NL) || (b == cst_pkg::CH_CR) ||
                    (b == cst_pkg::CH_TAB) || (b == cst_pkg::CH_VT) ||
                    (b == cst_pkg::CH_SPACE) || (b == cst_pkg::CH_FF);
  assign is_single = (b == cst_pkg::CH_LPAREN) || (b == cst_pkg::CH_RPAREN) ||
                     (b == cst_pkg::CH_SEMI) || (b == cst_pkg::CH_PLUS) ||
                     (b == cst_pkg::CH_MINUS) || (b == cst_pkg::CH_STAR);

  always_comb begin
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    nest_nxt  = nest_r;
    slash_nxt = slash_r;
    drop_nxt  = drop_r;
    run_start = 1'b0;
    pre_vld   = 1'b0;
    pre_res   = '{token_byte: cst_pkg::CH_NUL, byte_valid: 1'b0, token_end: 1'b1};
    main_vld  = 1'b0;
    main_res  = '{token_byte: b, byte_valid: 1'b1, token_end: 1'b0};

    if (in_end_of_text) begin
      if (slash_r) begin
        pre_vld = 1'b1;
        pre_res = '{token_byte: cst_pkg::CH_SLASH, byte_valid: 1'b1, token_end: 1'b1};
      end else if (mode_r == MODE_WORD || mode_r == MODE_BLOCK) begin
        pre_vld = 1'b1;
      end
      mode_nxt  = MODE_START;
      quote_nxt = 1'b0;
      nest_nxt  = '0;
      slash_nxt = 1'b0;
      drop_nxt  = 1'b0;
    end else if (slash_r) begin
      slash_nxt = 1'b0;
      if (b == cst_pkg::CH_SLASH) begin
        mode_nxt = MODE_COMMENT;
      end else begin
        pre_vld   = 1'b1;
        pre_res   = '{token_byte: cst_pkg::CH_SLASH, byte_valid: 1'b1, token_end: 1'b1};
        run_start = 1'b1;
      end
    end else begin
      unique case (mode_r)
        MODE_START: begin
          run_start = 1'b1;
        end
        MODE_WORD: begin
          if (is_space) begin
            pre_vld  = 1'b1;
            mode_nxt = MODE_START;
          end else if (b == cst_pkg::CH_SLASH || is_single) begin
            pre_vld   = 1'b1;
            run_start = 1'b1;
          end else begin
            main_vld = 1'b1;
          end
        end
        MODE_BLOCK: begin
          if (quote_r) begin
            if (drop_r) begin
              drop_nxt = 1'b0;
            end else if (b == cst_pkg::CH_BSLASH) begin
              drop_nxt = 1'b1;
            end else if (b == cst_pkg::CH_QUOTE) begin
              main_vld           = 1'b1;
              main_res.token_end = 1'b1;
              mode_nxt           = MODE_START;
              quote_nxt          = 1'b0;
            end else begin
              main_vld = 1'b1;
            end
          end else if (b == cst_pkg::CH_LBRACK) begin
            // saturate at the nesting limit
            if (nest_r < cst_pkg::NEST_W'(cst_pkg::NEST_LIMIT)) begin
              nest_nxt = nest_r + 1'b1;
            end
            main_vld = 1'b1;
          end else if (b == cst_pkg::CH_RBRACK) begin
            if (nest_r != '0) begin
              nest_nxt = nest_r - 1'b1;
            end
            main_vld = 1'b1;
            if (nest_nxt == '0) begin
              main_res.token_end = 1'b1;
              mode_nxt           = MODE_START;
            end
          end else begin
            main_vld = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (b == cst_pkg::CH_NL) begin
            mode_nxt = MODE_START;
          end
        end
        default: begin
          mode_nxt = MODE_START;
        end
      endcase
    end

    // handle the byte as if between tokens
    if (run_start) begin
      mode_nxt = MODE_START;
      if (is_space) begin
        mode_nxt = MODE_START;
      end else if (b == cst_pkg::CH_QUOTE) begin
        main_vld  = 1'b1;
        mode_nxt  = MODE_BLOCK;
        quote_nxt = 1'b1;
        drop_nxt  = 1'b0;
      end else if (b == cst_pkg::CH_LBRACK) begin
        main_vld  = 1'b1;
        mode_nxt  = MODE_BLOCK;
        quote_nxt = 1'b0;
        nest_nxt  = cst_pkg::NEST_W'(1);
      end else if (b == cst_pkg::CH_SLASH) begin
        slash_nxt = 1'b1;
      end else if (is_single) begin
        main_vld           = 1'b1;
        main_res.token_end = 1'b1;
      end else begin
        main_vld = 1'b1;
        mode_nxt = MODE_WORD;
      end
    end
  end

  always_comb begin
    push_job.two    = pre_vld && main_vld;
    push_job.first  = pre_vld ? pre_res : main_res;
    push_job.second = main_res;
    push            = accept && (pre_vld || main_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_START;
      quote_r <= 1'b0;
      nest_r  <= '0;
      slash_r <= 1'b0;
      drop_r  <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      nest_r  <= nest_nxt;
      slash_r <= slash_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

// ===== design/cst_queue.sv =====
// Short job queue between classifier and emitter, first-word fall-through.
// Depends on cst_pkg for the job type and depth.
module cst_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cst_pkg::job_t      push_job,
  input  logic               pop,
  output cst_pkg::job_t      head_job,
  output cst_pkg::q_status_t status
);

  cst_pkg::job_t              mem_r [cst_pkg::QDEPTH];
  logic [cst_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [cst_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [cst_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign head_job     = mem_r[rd_ptr_r];
  assign status.full  = (count_r == cst_pkg::QCNT_W'(cst_pkg::QDEPTH));
  assign status.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == cst_pkg::QPTR_W'(cst_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == cst_pkg::QPTR_W'(cst_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/cst_back.sv =====
// Emitter: unpacks queued jobs into single results behind an output register.
// Depends on cst_pkg; marks run_last on the final result of each job.
module cst_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cst_pkg::job_t      head_job,
  input  cst_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output cst_pkg::res_t      out_res,
  output logic               out_last
);

  logic          out_valid_r, out_valid_nxt;
  logic          sub_r, sub_nxt;
  cst_pkg::res_t res_r;
  logic          last_r;
  logic          load;
  logic          take;
  logic          last_pick;
  cst_pkg::res_t pick;

  assign load      = !out_valid_r || out_ready;
  assign take      = load && !q_status.empty;
  assign pick      = sub_r ? head_job.second : head_job.first;
  assign last_pick = sub_r || !head_job.two;
  assign pop       = take && last_pick;

  always_comb begin
    out_valid_nxt = out_valid_r;
    sub_nxt       = sub_r;
    if (load) begin
      out_valid_nxt = !q_status.empty;
    end
    if (take) begin
      sub_nxt = !last_pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r  <= pick;
      last_r <= last_pick;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

endmodule

// ===== design/char_stream_tokenizer_top.sv =====
// Tokeniser top level: the classifier writes each job into the job queue and
// the emitter then loads its results into the output register.
// Throughput: one input transaction per cycle while the job queue has room;
// the 4-entry job queue absorbs two-result items on the single output register.
// Synchronous active-low reset returns the scanner to between-token state and
// empties the queue and output register; no clearing pass is needed.
module char_stream_tokenizer_top (
  input logic          clk,
  input logic          rst_n,
  cst_in_if.sink       in_ch,
  cst_out_if.source    out_ch
);

  // classifier to queue
  logic               push;
  cst_pkg::job_t      push_job;

  // queue to emitter
  logic               pop;
  cst_pkg::job_t      head_job;
  cst_pkg::q_status_t q_status;

  cst_pkg::res_t      out_res;

  // front: scan state and classification, one transaction per cycle, queue not full
  cst_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_text_byte   (in_ch.text_byte),
    .in_end_of_text (in_ch.end_of_text),
    .q_status       (q_status),
    .push           (push),
    .push_job       (push_job)
  );

  // hold up to four pending jobs so either side may stall on its own
  cst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // back: one result per cycle into the output register, unless stalled by out_ready
  cst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res),
    .out_last  (out_ch.run_last)
  );

  assign out_ch.token_byte = out_res.token_byte;
  assign out_ch.byte_valid = out_res.byte_valid;
  assign out_ch.token_end  = out_res.token_end;

`ifndef SYNTH
  // never write a job into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("job pushed into full queue");

  // never retire a job from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("job popped from empty queue");

  // output register is empty in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid straight after reset");

  // a retiring pop loads the run's last result
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_ch.valid && out_ch.run_last)
    else $error("job retired without last result");
`endif

endmodule
